@@ rtl/doaq_pkg.sv @@
package doaq_pkg;

   // Default sizes of the queue.
   localparam int NUM_ALARMS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT = 48;

   // Fixed field widths of the request and response.
   localparam int OP_W = 2;
   localparam int SLOT_W = 4;
   localparam int DELAY_W = 32;
   localparam int THRESH_W = 20;
   localparam int MODE_W = 2;

   // Reset value of the wake lock threshold in milliseconds.
   localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd3000;

   // Largest remaining delay that the response can report.
   localparam logic [63:0] DELAY_MAX = 64'h0000_0000_FFFF_FFFF;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_SET = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   // Response kinds.
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   // Wake modes.
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOCK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALARM = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_INSERT,
      ST_FIRE,
      ST_STATUS
   } state_type;

   // Command broadcast from the sequencer to every cell of the list.
   typedef struct packed {
      logic              drop;
      logic              compact;
      logic              pop;
      logic [SLOT_W-1:0] drop_slot;
   } cell_cmd_type;

endpackage

@@ rtl/doaq_cell.sv @@
module doaq_cell #(
   parameter int TIME_BITS = doaq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  doaq_pkg::cell_cmd_type      cmd,
   input  logic                        tok_in_valid,
   input  logic [doaq_pkg::SLOT_W-1:0] tok_in_slot,
   input  logic [TIME_BITS-1:0]        tok_in_dl,
   input  logic                        left_hole,
   input  logic                        nb_valid,
   input  logic [doaq_pkg::SLOT_W-1:0] nb_slot,
   input  logic [TIME_BITS-1:0]        nb_dl,
   output logic                        ent_valid,
   output logic [doaq_pkg::SLOT_W-1:0] ent_slot,
   output logic [TIME_BITS-1:0]        ent_dl,
   output logic                        hole,
   output logic                        carry_busy,
   output logic                        tok_out_valid,
   output logic [doaq_pkg::SLOT_W-1:0] tok_out_slot,
   output logic [TIME_BITS-1:0]        tok_out_dl
);

   logic                        valid_ff, valid_in;
   logic [doaq_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [TIME_BITS-1:0]        dl_ff, dl_in;
   logic                        hole_ff, hole_in;
   logic                        carry_valid_ff, carry_valid_in;
   logic [doaq_pkg::SLOT_W-1:0] carry_slot_ff, carry_slot_in;
   logic [TIME_BITS-1:0]        carry_dl_ff, carry_dl_in;

   // A token handed in from the left is registered here before it is processed.
   assign carry_valid_in = tok_in_valid;
   assign carry_slot_in = tok_in_slot;
   assign carry_dl_in = tok_in_dl;

   // Entry update: insertion token, drop mark, hole compaction or pop.
   always_comb begin
      valid_in = valid_ff;
      slot_in = slot_ff;
      dl_in = dl_ff;
      hole_in = hole_ff;
      tok_out_valid = 1'b0;
      tok_out_slot = carry_slot_ff;
      tok_out_dl = carry_dl_ff;
      priority if (carry_valid_ff) begin
         if (!valid_ff) begin
            // The token lands in the first free cell.
            valid_in = 1'b1;
            slot_in = carry_slot_ff;
            dl_in = carry_dl_ff;
         end else begin
            tok_out_valid = 1'b1;
            // A token goes ahead of entries with an equal or later deadline.
            if (carry_dl_ff <= dl_ff) begin
               slot_in = carry_slot_ff;
               dl_in = carry_dl_ff;
               tok_out_slot = slot_ff;
               tok_out_dl = dl_ff;
            end
         end
      end else if (cmd.drop) begin
         if (valid_ff && (slot_ff == cmd.drop_slot)) begin
            valid_in = 1'b0;
            hole_in = 1'b1;
         end
      end else if (cmd.compact) begin
         if (hole_ff) begin
            // The hole pulls in the right neighbor and moves one cell right.
            hole_in = 1'b0;
            if (nb_valid) begin
               valid_in = 1'b1;
               slot_in = nb_slot;
               dl_in = nb_dl;
            end
         end else if (left_hole && valid_ff) begin
            valid_in = 1'b0;
            hole_in = 1'b1;
         end
      end else if (cmd.pop) begin
         valid_in = nb_valid;
         slot_in = nb_slot;
         dl_in = nb_dl;
      end else begin
         hole_in = hole_ff;
      end
   end

   // Control bits take reset; slot numbers and deadlines do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hole_ff <= 1'b0;
         carry_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hole_ff <= hole_in;
         carry_valid_ff <= carry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      dl_ff <= dl_in;
      carry_slot_ff <= carry_slot_in;
      carry_dl_ff <= carry_dl_in;
   end

   assign ent_valid = valid_ff;
   assign ent_slot = slot_ff;
   assign ent_dl = dl_ff;
   assign hole = hole_ff;
   assign carry_busy = carry_valid_ff;

endmodule

@@ rtl/deadline_ordered_alarm_queue.sv @@
// Set and cancel: a removal pass that drops the slot and closes the hole, then for a set an
// insertion pass that walks a token down the cell chain, then the status.
// Tick: each due alarm is popped in turn with a fired response, then the status.
// Results are registered before they appear; busy falls in the cycle the status shows.
// The receiver cannot stall.
// Synchronous reset empties the list, clears time and loads the threshold with 3000.
module deadline_ordered_alarm_queue #(
   parameter int NUM_ALARMS = doaq_pkg::NUM_ALARMS_DEFAULT,
   parameter int TIME_BITS = doaq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [doaq_pkg::OP_W-1:0]     req_op,
   input  logic [doaq_pkg::SLOT_W-1:0]   req_alarm_slot,
   input  logic [doaq_pkg::DELAY_W-1:0]  req_delay_ms,
   input  logic                          csr_wr_en,
   input  logic [doaq_pkg::THRESH_W-1:0] csr_wr_data,
   output logic                          rsp_valid,
   output logic                          rsp_kind,
   output logic [doaq_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [doaq_pkg::MODE_W-1:0]   rsp_wake_mode,
   output logic [doaq_pkg::DELAY_W-1:0]  rsp_next_delay_ms,
   output logic                          rsp_last
);

   doaq_pkg::state_type state_ff, state_in;

   logic [TIME_BITS-1:0]                time_ff, time_in;
   logic [doaq_pkg::THRESH_W-1:0]       thresh_ff, thresh_in;
   logic [doaq_pkg::SLOT_W-1:0]         new_slot_ff, new_slot_in;
   logic [TIME_BITS-1:0]                new_dl_ff, new_dl_in;
   logic                                new_set_ff, new_set_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_kind_in;
   logic [doaq_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [doaq_pkg::MODE_W-1:0]         rsp_mode_ff, rsp_mode_in;
   logic [doaq_pkg::DELAY_W-1:0]        rsp_delay_ff, rsp_delay_in;
   logic                                rsp_last_ff, rsp_last_in;

   doaq_pkg::cell_cmd_type              cmd;
   logic                                inject;

   logic [NUM_ALARMS-1:0]               ent_valid_vec;
   logic [doaq_pkg::SLOT_W-1:0]         ent_slot [NUM_ALARMS];
   logic [TIME_BITS-1:0]                ent_dl [NUM_ALARMS];
   logic [NUM_ALARMS-1:0]               hole_vec;
   logic [NUM_ALARMS-1:0]               carry_vec;
   logic [NUM_ALARMS-1:0]               left_hole_vec;
   logic [NUM_ALARMS-1:0]               nb_valid_vec;
   logic [doaq_pkg::SLOT_W-1:0]         nb_slot [NUM_ALARMS];
   logic [TIME_BITS-1:0]                nb_dl [NUM_ALARMS];
   logic [NUM_ALARMS:0]                 tok_valid;
   logic [doaq_pkg::SLOT_W-1:0]         tok_slot [NUM_ALARMS+1];
   logic [TIME_BITS-1:0]                tok_dl [NUM_ALARMS+1];

   logic                                accept;
   logic                                in_range;
   logic                                drop_req;
   logic                                any_hole;
   logic                                any_carry;
   logic                                fire_due;
   logic [TIME_BITS:0]                  dl_sum;
   logic [TIME_BITS-1:0]                head_rem;
   logic                                head_sat;
   logic                                head_lock;

   // Request acceptance and decode.
   assign busy = (state_ff != doaq_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign in_range = (int'(req_alarm_slot) < NUM_ALARMS);
   assign drop_req = ((req_op == doaq_pkg::OP_SET) || (req_op == doaq_pkg::OP_CANCEL))
                     && in_range;

   // List-wide status flags.
   assign any_hole = |hole_vec;
   assign any_carry = |carry_vec;
   assign fire_due = ent_valid_vec[0] && (ent_dl[0] <= time_ff);

   // New deadline, saturating at the largest time value.
   assign dl_sum = (TIME_BITS+1)'(time_ff) + (TIME_BITS+1)'(req_delay_ms);

   // Remaining delay of the list head.
   assign head_rem = (ent_dl[0] > time_ff) ? (ent_dl[0] - time_ff) : '0;
   assign head_sat = (head_rem > TIME_BITS'(doaq_pkg::DELAY_MAX));
   assign head_lock = (head_rem < TIME_BITS'(thresh_ff));

   // Neighbor wiring of the cell chain.
   assign left_hole_vec = {hole_vec[NUM_ALARMS-2:0], 1'b0};
   assign nb_valid_vec = {1'b0, ent_valid_vec[NUM_ALARMS-1:1]};

   // The insertion token enters at the head cell.
   assign tok_valid[0] = inject;
   assign tok_slot[0] = new_slot_ff;
   assign tok_dl[0] = new_dl_ff;

   for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
      if (i == NUM_ALARMS - 1) begin : g_tail
         assign nb_slot[i] = '0;
         assign nb_dl[i] = '0;
      end else begin : g_body
         assign nb_slot[i] = ent_slot[i+1];
         assign nb_dl[i] = ent_dl[i+1];
      end

      doaq_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .tok_in_valid (tok_valid[i]),
         .tok_in_slot  (tok_slot[i]),
         .tok_in_dl    (tok_dl[i]),
         .left_hole    (left_hole_vec[i]),
         .nb_valid     (nb_valid_vec[i]),
         .nb_slot      (nb_slot[i]),
         .nb_dl        (nb_dl[i]),
         .ent_valid    (ent_valid_vec[i]),
         .ent_slot     (ent_slot[i]),
         .ent_dl       (ent_dl[i]),
         .hole         (hole_vec[i]),
         .carry_busy   (carry_vec[i]),
         .tok_out_valid(tok_valid[i+1]),
         .tok_out_slot (tok_slot[i+1]),
         .tok_out_dl   (tok_dl[i+1])
      );
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         doaq_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (drop_req) begin
                  state_in = doaq_pkg::ST_DROP;
               end else if (req_op == doaq_pkg::OP_TICK) begin
                  state_in = doaq_pkg::ST_FIRE;
               end else begin
                  state_in = doaq_pkg::ST_STATUS;
               end
            end
         end
         doaq_pkg::ST_DROP: begin
            if (!any_hole) begin
               state_in = new_set_ff ? doaq_pkg::ST_INSERT : doaq_pkg::ST_STATUS;
            end
         end
         doaq_pkg::ST_INSERT: begin
            if (!any_carry) begin
               state_in = doaq_pkg::ST_STATUS;
            end
         end
         doaq_pkg::ST_FIRE: begin
            if (!fire_due) begin
               state_in = doaq_pkg::ST_STATUS;
            end
         end
         doaq_pkg::ST_STATUS: begin
            state_in = doaq_pkg::ST_IDLE;
         end
         default: begin
            state_in = doaq_pkg::ST_IDLE;
         end
      endcase
   end

   // Cell commands and the next response.
   always_comb begin
      cmd = '0;
      cmd.drop_slot = req_alarm_slot;
      inject = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_kind_in = doaq_pkg::KIND_STATUS;
      rsp_slot_in = ent_slot[0];
      rsp_mode_in = doaq_pkg::MODE_NONE;
      rsp_delay_in = '0;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         doaq_pkg::ST_IDLE: begin
            cmd.drop = accept && drop_req;
         end
         doaq_pkg::ST_DROP: begin
            cmd.compact = 1'b1;
            inject = !any_hole && new_set_ff;
         end
         doaq_pkg::ST_INSERT: begin
            inject = 1'b0;
         end
         doaq_pkg::ST_FIRE: begin
            if (fire_due) begin
               cmd.pop = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in = doaq_pkg::KIND_FIRED;
            end
         end
         doaq_pkg::ST_STATUS: begin
            rsp_valid_in = 1'b1;
            rsp_last_in = 1'b1;
            if (ent_valid_vec[0]) begin
               rsp_mode_in = head_lock ? doaq_pkg::MODE_LOCK : doaq_pkg::MODE_ALARM;
               rsp_delay_in = head_sat ? '1 : head_rem[doaq_pkg::DELAY_W-1:0];
            end else begin
               rsp_slot_in = '0;
            end
         end
         default: begin
            inject = 1'b0;
         end
      endcase
   end

   // Time counter, threshold register and the held request.
   always_comb begin
      time_in = time_ff;
      if (accept && (req_op == doaq_pkg::OP_TICK) && (time_ff != '1)) begin
         time_in = time_ff + 1'b1;
      end
      thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;
      new_slot_in = accept ? req_alarm_slot : new_slot_ff;
      new_dl_in = new_dl_ff;
      new_set_in = new_set_ff;
      if (accept) begin
         new_dl_in = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
         new_set_in = (req_op == doaq_pkg::OP_SET);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= doaq_pkg::ST_IDLE;
         time_ff <= '0;
         thresh_ff <= doaq_pkg::THRESH_RESET;
         new_set_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff <= time_in;
         thresh_ff <= thresh_in;
         new_set_ff <= new_set_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_slot_ff <= new_slot_in;
      new_dl_ff <= new_dl_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_delay_ff <= rsp_delay_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_wake_mode = rsp_mode_ff;
   assign rsp_next_delay_ms = rsp_delay_ff;
   assign rsp_last = rsp_last_ff;

`ifndef ASSERT_OFF
   // An insertion token never runs off the tail of a full list.
   a_no_token_loss: assert property (@(posedge clock) disable iff (reset)
      !tok_valid[NUM_ALARMS])
      else $error("insertion token dropped at list tail");

   // A removal leaves at most one hole in the list.
   a_single_hole: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hole_vec))
      else $error("more than one hole in the list");

   // Between requests the list is a packed prefix with no token or hole in flight.
   a_idle_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == doaq_pkg::ST_IDLE) |->
         (((ent_valid_vec & (ent_valid_vec + 1'b1)) == '0) && !any_hole && !any_carry))
      else $error("list not packed while idle");

   // The final response of a request coincides with readiness for the next one.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy still high at final response");
`endif

endmodule

@@ dv/alarm_queue_checker.sv @@
`timescale 1ns / 100ps

module alarm_queue_checker #(
   parameter int NUM_ALARMS = doaq_pkg::NUM_ALARMS_DEFAULT,
   parameter int TIME_BITS = doaq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [doaq_pkg::OP_W-1:0]     req_op,
   input  logic [doaq_pkg::SLOT_W-1:0]   req_alarm_slot,
   input  logic [doaq_pkg::DELAY_W-1:0]  req_delay_ms,
   input  logic                          csr_wr_en,
   input  logic [doaq_pkg::THRESH_W-1:0] csr_wr_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_kind,
   input  logic [doaq_pkg::SLOT_W-1:0]   rsp_slot_out,
   input  logic [doaq_pkg::MODE_W-1:0]   rsp_wake_mode,
   input  logic [doaq_pkg::DELAY_W-1:0]  rsp_next_delay_ms,
   input  logic                          rsp_last,
   output int unsigned                   reports_waiting,
   output int unsigned                   fail_count
);
   import doaq_pkg::*;

   localparam logic [TIME_BITS-1:0] TIME_LIMIT = '1;

   // One response of the queue, as it appears on the rsp_ ports.
   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [MODE_W-1:0]  mode;
      logic [DELAY_W-1:0] delay;
      logic               last;
   } queue_report_type;

   // Shadow copy of the alarm queue.
   logic [TIME_BITS-1:0] now_ms;
   logic [TIME_BITS-1:0] deadline_ms [NUM_ALARMS];
   logic                 armed_flag [NUM_ALARMS];
   int unsigned          deadline_order[$];
   logic [THRESH_W-1:0]  lock_threshold;

   queue_report_type expected_reports[$];
   int unsigned      mismatch_tally = 0;

   // Remove a slot from the deadline order, keeping the rest in place.
   function automatic void unlink_slot(input int unsigned slot);
      for (int i = 0; i < deadline_order.size(); i++) begin
         if (deadline_order[i] == slot) begin
            deadline_order.delete(i);
            return;
         end
      end
   endfunction

   // Insert a slot ahead of every slot whose deadline is not earlier.
   function automatic void link_slot(input int unsigned slot);
      int pos;
      pos = 0;
      while (pos < deadline_order.size() &&
             deadline_ms[deadline_order[pos]] < deadline_ms[slot])
         pos++;
      deadline_order.insert(pos, slot);
   endfunction

   function automatic void add_report(input logic kind, input logic [SLOT_W-1:0] slot,
                                      input logic [MODE_W-1:0] mode,
                                      input logic [DELAY_W-1:0] delay, input logic last);
      queue_report_type item;
      item.kind = kind;
      item.slot = slot;
      item.mode = mode;
      item.delay = delay;
      item.last = last;
      expected_reports.push_back(item);
   endfunction

   // Apply one request to the shadow queue and record the responses it causes.
   function automatic void predict_request(input logic [OP_W-1:0] op,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [DELAY_W-1:0] delay);
      logic [TIME_BITS-1:0] span;
      logic [TIME_BITS-1:0] remain;
      int unsigned          head;
      span = TIME_BITS'(delay);
      if (op == OP_SET && slot < NUM_ALARMS) begin
         if (armed_flag[slot])
            unlink_slot(slot);
         deadline_ms[slot] = (span > TIME_LIMIT - now_ms) ? TIME_LIMIT : now_ms + span;
         armed_flag[slot] = 1'b1;
         link_slot(slot);
      end else if (op == OP_CANCEL && slot < NUM_ALARMS) begin
         if (armed_flag[slot])
            unlink_slot(slot);
         armed_flag[slot] = 1'b0;
         deadline_ms[slot] = '0;
      end else if (op == OP_TICK) begin
         if (now_ms < TIME_LIMIT)
            now_ms++;
         // Every alarm due by the new time fires, earliest first.
         while (deadline_order.size() > 0 && deadline_ms[deadline_order[0]] <= now_ms) begin
            head = deadline_order.pop_front();
            armed_flag[head] = 1'b0;
            deadline_ms[head] = '0;
            add_report(KIND_FIRED, SLOT_W'(head), MODE_NONE, '0, 1'b0);
         end
      end

      // Every request closes with the status of the earliest pending alarm.
      if (deadline_order.size() > 0) begin
         head = deadline_order[0];
         remain = (deadline_ms[head] > now_ms) ? deadline_ms[head] - now_ms : '0;
         add_report(KIND_STATUS, SLOT_W'(head),
                    (remain < lock_threshold) ? MODE_LOCK : MODE_ALARM,
                    (64'(remain) > DELAY_MAX) ? '1 : DELAY_W'(remain), 1'b1);
      end else begin
         add_report(KIND_STATUS, '0, MODE_NONE, '0, 1'b1);
      end
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_tally++;
      end
   endtask

   // Compare one response with the oldest outstanding expectation.
   task automatic check_response();
      queue_report_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: response with nothing expected, expected none, %s %0h %0h %0h %0h %0h",
                  $time, "actual", rsp_kind, rsp_slot_out, rsp_wake_mode,
                  rsp_next_delay_ms, rsp_last);
         mismatch_tally++;
      end else begin
         want = expected_reports.pop_front();
         check_field("kind", 32'(want.kind), 32'(rsp_kind));
         check_field("slot_out", 32'(want.slot), 32'(rsp_slot_out));
         check_field("wake_mode", 32'(want.mode), 32'(rsp_wake_mode));
         check_field("next_delay_ms", want.delay, rsp_next_delay_ms);
         check_field("last", 32'(want.last), 32'(rsp_last));
      end
   endtask

   // Watch both channels and the register port on every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         now_ms = '0;
         for (int s = 0; s < NUM_ALARMS; s++) begin
            deadline_ms[s] = '0;
            armed_flag[s] = 1'b0;
         end
         deadline_order.delete();
         expected_reports.delete();
         lock_threshold = THRESH_RESET;
      end else begin
         if (rsp_valid)
            check_response();
         if (csr_wr_en)
            lock_threshold = csr_wr_data;
         if (start && !busy)
            predict_request(req_op, req_alarm_slot, req_delay_ms);
      end
      reports_waiting <= expected_reports.size();
      fail_count <= mismatch_tally;
   end

endmodule

@@ dv/tb_deadline_ordered_alarm_queue.sv @@
`timescale 1ns / 100ps

module tb_deadline_ordered_alarm_queue;
   import doaq_pkg::*;

   // Op code that the queue does not define.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [SLOT_W-1:0]   req_alarm_slot;
   logic [DELAY_W-1:0]  req_delay_ms;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;
   logic                rsp_valid;
   logic                rsp_kind;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [MODE_W-1:0]   rsp_wake_mode;
   logic [DELAY_W-1:0]  rsp_next_delay_ms;
   logic                rsp_last;
   int unsigned         reports_waiting;
   int unsigned         fail_count;
   int unsigned         idle_pct;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   deadline_ordered_alarm_queue i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_alarm_slot    (req_alarm_slot),
      .req_delay_ms      (req_delay_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_wake_mode     (rsp_wake_mode),
      .rsp_next_delay_ms (rsp_next_delay_ms),
      .rsp_last          (rsp_last)
   );

   alarm_queue_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_alarm_slot    (req_alarm_slot),
      .req_delay_ms      (req_delay_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_wake_mode     (rsp_wake_mode),
      .rsp_next_delay_ms (rsp_next_delay_ms),
      .rsp_last          (rsp_last),
      .reports_waiting   (reports_waiting),
      .fail_count        (fail_count)
   );

   // Issue one request, possibly after an idle gap, and return at the edge that takes it.
   // Start stays high afterwards so back-to-back requests need no extra edge.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                               input logic [DELAY_W-1:0] delay);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct)
         gap = $urandom_range(1, 24);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_alarm_slot <= slot;
      req_delay_ms <= delay;
      do @(posedge clock); while (busy);
   endtask

   // Stop issuing and wait until every expected response has come back.
   task automatic drain_queue();
      start <= 1'b0;
      @(posedge clock);
      while (busy || reports_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hand-picked requests: empty queue, ties, re-arming, boundaries of the threshold.
   task automatic run_directed();
      send_request(OP_TICK, 4'd0, 32'd0);
      send_request(OP_UNUSED, 4'd15, 32'hFFFF_FFFF);
      send_request(OP_CANCEL, 4'd5, 32'd0);
      // A zero delay alarm waits for the next tick.
      send_request(OP_SET, 4'd0, 32'd0);
      send_request(OP_TICK, 4'd0, 32'd0);
      send_request(OP_SET, 4'd15, 32'hFFFF_FFFF);
      send_request(OP_SET, 4'd7, 32'd2999);
      send_request(OP_SET, 4'd8, 32'd3000);
      // Equal deadline: the newer alarm goes first.
      send_request(OP_SET, 4'd9, 32'd3000);
      send_request(OP_SET, 4'd8, 32'd1);
      send_request(OP_CANCEL, 4'd15, 32'd0);
      send_request(OP_TICK, 4'd3, 32'd77);
      send_request(OP_SET, 4'd3, 32'd2);
      send_request(OP_SET, 4'd4, 32'd2);
      send_request(OP_TICK, 4'd0, 32'd0);
      send_request(OP_TICK, 4'd0, 32'd0);
      send_request(OP_CANCEL, 4'd7, 32'd0);
      send_request(OP_CANCEL, 4'd9, 32'd0);
      send_request(OP_UNUSED, 4'd0, 32'd0);
      send_request(OP_SET, 4'd1, 32'h8000_0000);
      send_request(OP_SET, 4'd2, 32'h7FFF_FFFF);
   endtask

   // Random requests, weighted toward short alarms and ticks so that alarms really fire.
   task automatic run_random(input int unsigned item_goal);
      int unsigned        sent;
      int unsigned        pick;
      int unsigned        burst_len;
      int unsigned        first_slot;
      int unsigned        due;
      logic [DELAY_W-1:0] span;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            // Many alarms on one deadline, then ticks until they all fire together.
            burst_len = $urandom_range(2, 16);
            first_slot = $urandom_range(0, 15);
            due = $urandom_range(0, 3);
            for (int k = 0; k < burst_len; k++)
               send_request(OP_SET, SLOT_W'((first_slot + k) % 16), DELAY_W'(due));
            repeat (due + 1) send_request(OP_TICK, SLOT_W'($urandom_range(0, 15)), $urandom());
            sent += burst_len + due + 1;
         end else if (pick < 38) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: span = $urandom_range(0, 40);
               6, 7: span = $urandom_range(0, 8000);
               default: span = $urandom();
            endcase
            send_request(OP_SET, SLOT_W'($urandom_range(0, 15)), span);
            sent++;
         end else if (pick < 50) begin
            send_request(OP_CANCEL, SLOT_W'($urandom_range(0, 15)), $urandom());
            sent++;
         end else if (pick < 95) begin
            send_request(OP_TICK, SLOT_W'($urandom_range(0, 15)), $urandom());
            sent++;
         end else begin
            send_request(OP_UNUSED, SLOT_W'($urandom_range(0, 15)), $urandom());
            sent++;
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_TICK;
      req_alarm_slot <= '0;
      req_delay_ms <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      idle_pct = 38;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain_queue();

      // Threshold zero: every pending alarm uses the wake alarm.
      write_threshold('0);
      run_random(133);
      drain_queue();

      // Largest threshold: nearly everything uses the wake lock.
      idle_pct = 65;
      write_threshold('1);
      run_random(133);
      drain_queue();

      // Small threshold that the short delays straddle, with no idling.
      idle_pct = 0;
      write_threshold(THRESH_W'($urandom_range(1, 50)));
      run_random(133);
      drain_queue();

      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/doaq_pkg.sv
rtl/doaq_cell.sv
rtl/deadline_ordered_alarm_queue.sv
dv/alarm_queue_checker.sv
dv/tb_deadline_ordered_alarm_queue.sv
